[sv/hrarg_pkg.sv]
// hrarg_pkg: shared types, constants and register codes for the heart-rate report gate
// depends on nothing; used by the channel interfaces, the window unit and the top level
`timescale 1ns / 1ps

package hrarg_pkg;

  localparam int WINDOW_SIZE = 5;
  localparam int SUM_W       = $clog2(WINDOW_SIZE * 255 + 1);
  localparam int POS_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  // floor(sum / WINDOW_SIZE) as (sum * RECIP) >> RECIP_SHIFT, exact for sums below 2^12
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + WINDOW_SIZE - 1) / WINDOW_SIZE;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int TIME_W  = 32;
  localparam int BPM_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] EVAL_PERIOD_RST   = 32'd3000;
  localparam logic [TIME_W-1:0] CRIT_INTERVAL_RST = 32'd10000;
  localparam logic [TIME_W-1:0] NORM_INTERVAL_RST = 32'd300000;
  localparam logic [BPM_W-1:0]  THRESHOLD_RST     = 8'd20;
  localparam logic              CRIT_MODE_RST     = 1'b1;

  localparam int FLAG_WIDE_BIT = 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CRITICAL_MODE    = 3'd0,
    CFG_EVALUATE_PERIOD  = 3'd1,
    CFG_CRITICAL_INTERVAL = 3'd2,
    CFG_NORMAL_INTERVAL  = 3'd3,
    CFG_CHANGE_THRESHOLD = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    CMD_MEASURE = 1'b0,
    CMD_CLEAR   = 1'b1
  } command_e;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] time_ms;
    logic [7:0]        format_flags;
    logic [7:0]        value_low;
    logic [7:0]        value_high;
  } meas_item_t;

  typedef struct packed {
    logic [BPM_W-1:0] average_bpm;
    logic             alert_flags;
  } report_item_t;

  typedef struct packed {
    logic update;
    logic clear;
  } win_ctrl_t;

endpackage

[sv/hrarg_intf.sv]
// hrarg channel interfaces: measurement input, report output and register write
// depends on hrarg_pkg for the payload types and widths
`timescale 1ns / 1ps

interface hrarg_meas_if;
  logic                  valid;
  logic                  ready;
  hrarg_pkg::meas_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hrarg_report_if;
  logic                    valid;
  logic                    ready;
  hrarg_pkg::report_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hrarg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [hrarg_pkg::CFG_IDX_W-1:0]     index;
  logic [hrarg_pkg::CFG_DATA_W-1:0]    wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[sv/hrarg_window.sv]
// hrarg_window: ring of recent heart-rate values with running sum and floor average
// depends on hrarg_pkg for window size, widths and the control struct
`timescale 1ns / 1ps

module hrarg_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hrarg_pkg::win_ctrl_t        ctrl_i,
  input  logic [hrarg_pkg::BPM_W-1:0] bpm_i,
  output logic [hrarg_pkg::BPM_W-1:0] avg_o
);

  logic [hrarg_pkg::BPM_W-1:0]  hist_q [hrarg_pkg::WINDOW_SIZE];
  logic [hrarg_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [hrarg_pkg::SUM_W-1:0]  sum_q, sum_d;
  logic [hrarg_pkg::PROD_W-1:0] prod;

  assign sum_d = sum_q - hrarg_pkg::SUM_W'(hist_q[pos_q]) + hrarg_pkg::SUM_W'(bpm_i);
  assign pos_d = (pos_q == hrarg_pkg::POS_W'(hrarg_pkg::WINDOW_SIZE - 1))
               ? '0 : pos_q + 1'b1;

  // average of the window after this value is added
  assign prod  = hrarg_pkg::PROD_W'(sum_d) * hrarg_pkg::PROD_W'(hrarg_pkg::RECIP);
  assign avg_o = prod[hrarg_pkg::RECIP_SHIFT +: hrarg_pkg::BPM_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < hrarg_pkg::WINDOW_SIZE; i++) begin
        hist_q[i] <= '0;
      end
      pos_q <= '0;
      sum_q <= '0;
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < hrarg_pkg::WINDOW_SIZE; i++) begin
        hist_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (ctrl_i.update) begin
      hist_q[pos_q] <= bpm_i;
      sum_q         <= sum_d;
      pos_q         <= pos_d;
    end
  end

endmodule

[sv/heart_rate_average_report_gate_core.sv]
// heart_rate_average_report_gate_core: top level of the heart-rate average report gate
// depends on hrarg_pkg, the hrarg channel interfaces and hrarg_window
`timescale 1ns / 1ps

// Usage:
// meas_i takes one measurement or clear transaction per cycle (valid/ready).
// report_o carries the average and alert flag when a report is due.
// cfg_i writes one register per transaction and is always ready; writes to an
// index past the register list are dropped. Write registers only while idle.
// An accepted transaction is captured in an input register and then evaluated;
// its report is registered in the result register, which drives report_o,
// once that register is free. Throughput is one transaction per cycle while
// the receiver does not stall; ring update and evaluation sit in between.
// A transaction that yields no report still passes through the result stage.
// If the receiver stalls, the report is held and the input register fills;
// meas_i then drops ready until the report is taken.
// Reset clears the ring, the sum, all time stamps and the last sent average,
// and loads the register defaults (critical mode on, 3000 ms evaluation
// period, 10000 / 300000 ms send intervals, threshold 20).

module heart_rate_average_report_gate_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  hrarg_meas_if.sink             meas_i,
  hrarg_report_if.source         report_o,
  hrarg_cfg_if.sink              cfg_i
);

  // configuration registers
  logic                               crit_mode_q;
  logic [hrarg_pkg::TIME_W-1:0]       eval_period_q;
  logic [hrarg_pkg::TIME_W-1:0]       crit_interval_q;
  logic [hrarg_pkg::TIME_W-1:0]       norm_interval_q;
  logic [hrarg_pkg::BPM_W-1:0]        threshold_q;

  // input stage
  logic                               in_vld_q;
  hrarg_pkg::meas_item_t              in_item_q;

  // result stage
  logic                               out_vld_q, out_vld_d;
  hrarg_pkg::report_item_t            out_item_q, out_item_d;

  // evaluation state
  logic [hrarg_pkg::TIME_W-1:0]       last_eval_q, last_send_q;
  logic [hrarg_pkg::BPM_W-1:0]        last_sent_q;

  logic                               adv;
  logic                               is_measure;
  logic                               is_clear;
  logic [hrarg_pkg::BPM_W-1:0]        bpm;
  logic [hrarg_pkg::BPM_W-1:0]        avg;
  logic [hrarg_pkg::BPM_W-1:0]        diff;
  logic [hrarg_pkg::TIME_W-1:0]       interval;
  logic [hrarg_pkg::TIME_W-1:0]       since_eval, since_send;
  logic                               do_eval;
  logic                               do_send;
  hrarg_pkg::win_ctrl_t               win_ctrl;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_mode_q     <= hrarg_pkg::CRIT_MODE_RST;
      eval_period_q   <= hrarg_pkg::EVAL_PERIOD_RST;
      crit_interval_q <= hrarg_pkg::CRIT_INTERVAL_RST;
      norm_interval_q <= hrarg_pkg::NORM_INTERVAL_RST;
      threshold_q     <= hrarg_pkg::THRESHOLD_RST;
    end else if (cfg_i.valid) begin
      case (hrarg_pkg::cfg_reg_e'(cfg_i.index))
        hrarg_pkg::CFG_CRITICAL_MODE:     crit_mode_q     <= cfg_i.wdata[0];
        hrarg_pkg::CFG_EVALUATE_PERIOD:   eval_period_q   <= cfg_i.wdata;
        hrarg_pkg::CFG_CRITICAL_INTERVAL: crit_interval_q <= cfg_i.wdata;
        hrarg_pkg::CFG_NORMAL_INTERVAL:   norm_interval_q <= cfg_i.wdata;
        hrarg_pkg::CFG_CHANGE_THRESHOLD:  threshold_q <= cfg_i.wdata[hrarg_pkg::BPM_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv          = in_vld_q && (!out_vld_q || report_o.ready);
  assign meas_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (meas_i.ready) begin
      in_vld_q <= meas_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas_i.valid && meas_i.ready) begin
      in_item_q <= meas_i.data;
    end
  end

  assign is_measure = adv && (in_item_q.command == hrarg_pkg::CMD_MEASURE);
  assign is_clear   = adv && (in_item_q.command == hrarg_pkg::CMD_CLEAR);

  // 16-bit values saturate at 255
  always_comb begin
    if (in_item_q.format_flags[hrarg_pkg::FLAG_WIDE_BIT] && (in_item_q.value_high != 8'd0)) begin
      bpm = '1;
    end else begin
      bpm = in_item_q.value_low;
    end
  end

  assign win_ctrl = '{update: is_measure, clear: is_clear};

  hrarg_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .bpm_i  (bpm),
    .avg_o  (avg)
  );

  assign since_eval = in_item_q.time_ms - last_eval_q;
  assign since_send = in_item_q.time_ms - last_send_q;
  assign interval   = crit_mode_q ? crit_interval_q : norm_interval_q;
  assign diff       = (avg > last_sent_q) ? avg - last_sent_q : last_sent_q - avg;
  assign do_eval    = is_measure && (since_eval >= eval_period_q);
  assign do_send    = do_eval && ((since_send > interval) || (diff > threshold_q));

  always_comb begin
    out_vld_d  = out_vld_q;
    out_item_d = out_item_q;
    if (adv) begin
      out_vld_d = do_send;
      if (do_send) begin
        out_item_d.average_bpm = avg;
        out_item_d.alert_flags = crit_mode_q;
      end
    end else if (report_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      last_eval_q <= '0;
      last_send_q <= '0;
      last_sent_q <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (do_eval) begin
        last_eval_q <= in_item_q.time_ms;
      end
      if (do_send) begin
        last_send_q <= in_item_q.time_ms;
        last_sent_q <= avg;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign report_o.valid = out_vld_q;
  assign report_o.data  = out_item_q;

  // a new report only follows an evaluated measurement
  a_report_from_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(is_measure))
    else $error("report raised without a measurement");

  // send time moves only together with a pending report
  a_send_time_with_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(last_send_q) |-> out_vld_q)
    else $error("send time changed without a report");

  // a pending report always carries the last sent average
  a_report_matches_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_item_q.average_bpm == last_sent_q))
    else $error("pending report differs from last sent average");

endmodule

[dv/testbench.sv]
// testbench: self-checking bench for heart_rate_average_report_gate_core
// drives measurement, clear and register transactions with random idling and checks each report
// against a model of the ring average and send gate; needs hrarg_pkg and the hrarg interfaces
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_REPORTED   = 10;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 230;
  localparam int unsigned STRETCH_ITEMS  = 40;
  localparam int unsigned CFG_IDX_UNUSED_LO = hrarg_pkg::CFG_CHANGE_THRESHOLD + 1;
  localparam int unsigned CFG_IDX_UNUSED_HI = (1 << hrarg_pkg::CFG_IDX_W) - 1;

  class report_gate_scoreboard;
    logic                         crit_mode;
    logic [hrarg_pkg::TIME_W-1:0] eval_period;
    logic [hrarg_pkg::TIME_W-1:0] crit_interval;
    logic [hrarg_pkg::TIME_W-1:0] norm_interval;
    logic [hrarg_pkg::BPM_W-1:0]  threshold;
    logic [hrarg_pkg::BPM_W-1:0]  ring [hrarg_pkg::WINDOW_SIZE];
    int unsigned                  ring_pos;
    int unsigned                  ring_sum;
    logic [hrarg_pkg::TIME_W-1:0] last_eval_ms;
    logic [hrarg_pkg::TIME_W-1:0] last_send_ms;
    logic [hrarg_pkg::BPM_W-1:0]  last_sent_bpm;
    hrarg_pkg::report_item_t      expected_reports[$];
    int unsigned                  failures;

    function new();
      crit_mode     = hrarg_pkg::CRIT_MODE_RST;
      eval_period   = hrarg_pkg::EVAL_PERIOD_RST;
      crit_interval = hrarg_pkg::CRIT_INTERVAL_RST;
      norm_interval = hrarg_pkg::NORM_INTERVAL_RST;
      threshold     = hrarg_pkg::THRESHOLD_RST;
      foreach (ring[i]) ring[i] = '0;
      ring_pos      = 0;
      ring_sum      = 0;
      last_eval_ms  = '0;
      last_send_ms  = '0;
      last_sent_bpm = '0;
      failures      = 0;
    endfunction

    function void write_reg(logic [hrarg_pkg::CFG_IDX_W-1:0] idx,
                            logic [hrarg_pkg::CFG_DATA_W-1:0] wdata);
      case (idx)
        hrarg_pkg::CFG_CRITICAL_MODE:     crit_mode = wdata[0];
        hrarg_pkg::CFG_EVALUATE_PERIOD:   eval_period = wdata;
        hrarg_pkg::CFG_CRITICAL_INTERVAL: crit_interval = wdata;
        hrarg_pkg::CFG_NORMAL_INTERVAL:   norm_interval = wdata;
        hrarg_pkg::CFG_CHANGE_THRESHOLD:  threshold = wdata[hrarg_pkg::BPM_W-1:0];
        default: ;
      endcase
    endfunction

    function void flag_failure(string msg);
      failures++;
      if (failures <= MAX_REPORTED) $display("mismatch: %s", msg);
    endfunction

    // accepted transaction: update ring and gate, queue a report when one is due
    function void predict_report(hrarg_pkg::meas_item_t it);
      logic [15:0]                  wide;
      logic [hrarg_pkg::BPM_W-1:0]  bpm;
      logic [hrarg_pkg::BPM_W-1:0]  avg;
      logic [hrarg_pkg::BPM_W-1:0]  delta;
      logic [hrarg_pkg::TIME_W-1:0] since_eval;
      logic [hrarg_pkg::TIME_W-1:0] since_send;
      logic [hrarg_pkg::TIME_W-1:0] interval;
      hrarg_pkg::report_item_t      rep;
      if (it.command == hrarg_pkg::CMD_CLEAR) begin
        foreach (ring[i]) ring[i] = '0;
        ring_sum = 0;
        return;
      end
      wide = {it.value_high, it.value_low};
      if (it.format_flags[hrarg_pkg::FLAG_WIDE_BIT]) begin
        bpm = (wide > 16'd255) ? 8'hFF : wide[7:0];
      end else begin
        bpm = it.value_low;
      end
      ring_sum = ring_sum - ring[ring_pos] + bpm;
      ring[ring_pos] = bpm;
      ring_pos = (ring_pos + 1 == hrarg_pkg::WINDOW_SIZE) ? 0 : ring_pos + 1;
      since_eval = it.time_ms - last_eval_ms;
      if (since_eval < eval_period) return;
      last_eval_ms = it.time_ms;
      avg = hrarg_pkg::BPM_W'(ring_sum / hrarg_pkg::WINDOW_SIZE);
      delta = (avg > last_sent_bpm) ? avg - last_sent_bpm : last_sent_bpm - avg;
      interval = crit_mode ? crit_interval : norm_interval;
      since_send = it.time_ms - last_send_ms;
      if (since_send > interval || delta > threshold) begin
        last_send_ms  = it.time_ms;
        last_sent_bpm = avg;
        rep.average_bpm = avg;
        rep.alert_flags = crit_mode;
        expected_reports.push_back(rep);
      end
    endfunction

    function void check_report(hrarg_pkg::report_item_t got);
      hrarg_pkg::report_item_t want;
      if (expected_reports.size() == 0) begin
        flag_failure($sformatf("report with none expected: average_bpm %0d alert_flags %0b",
                               got.average_bpm, got.alert_flags));
        return;
      end
      want = expected_reports.pop_front();
      if (got.average_bpm !== want.average_bpm) begin
        flag_failure($sformatf("average_bpm expected %0d got %0d",
                               want.average_bpm, got.average_bpm));
      end
      if (got.alert_flags !== want.alert_flags) begin
        flag_failure($sformatf("alert_flags expected %0b got %0b",
                               want.alert_flags, got.alert_flags));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hrarg_meas_if   meas_if ();
  hrarg_report_if report_if ();
  hrarg_cfg_if    cfg_if ();

  heart_rate_average_report_gate_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .meas_i   (meas_if),
    .report_o (report_if),
    .cfg_i    (cfg_if)
  );

  report_gate_scoreboard        sb;
  logic                         tx_idling   = 1'b1;
  logic                         rx_stalling = 1'b1;
  logic [hrarg_pkg::TIME_W-1:0] cur_ms      = '0;
  int unsigned                  quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_meas(input hrarg_pkg::command_e cmd,
                           input logic [hrarg_pkg::TIME_W-1:0] stamp,
                           input logic [7:0] flags, input logic [7:0] lo,
                           input logic [7:0] hi);
    hrarg_pkg::meas_item_t it;
    int unsigned           gap;
    it.command      = cmd;
    it.time_ms      = stamp;
    it.format_flags = flags;
    it.value_low    = lo;
    it.value_high   = hi;
    gap = tx_idling ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      meas_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    meas_if.valid <= 1'b1;
    meas_if.data  <= it;
    do @(posedge clk_i); while (meas_if.ready !== 1'b1);
    sb.predict_report(it);
    cur_ms = stamp;
  endtask

  // leaves valid high so back-to-back writes need one assignment per step
  task automatic write_reg(input logic [hrarg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hrarg_pkg::CFG_DATA_W-1:0] wdata);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= wdata;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, wdata);
  endtask

  // wait until every report is in and the pipeline has emptied
  task automatic settle();
    meas_if.valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [hrarg_pkg::TIME_W-1:0] pick_span(
      logic [hrarg_pkg::TIME_W-1:0] dflt);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom();
      3, 4: return dflt;
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  initial begin
    logic                         mode;
    logic [hrarg_pkg::TIME_W-1:0] period;
    logic [hrarg_pkg::TIME_W-1:0] crit_iv;
    logic [hrarg_pkg::TIME_W-1:0] norm_iv;
    logic [hrarg_pkg::BPM_W-1:0]  thr;
    logic [31:0]                  noise;
    int unsigned                  step_max;
    hrarg_pkg::command_e          cmd;
    logic [hrarg_pkg::TIME_W-1:0] stamp;
    logic [7:0]                   flags;
    logic [7:0]                   lo;
    logic [7:0]                   hi;

    sb = new();
    rst_ni        <= 1'b0;
    meas_if.valid <= 1'b0;
    meas_if.data  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.wdata  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under reset register values
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd100, 8'h00, 8'h00, 8'h00);
    // upper flag bits, high byte ignored
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd3000, 8'hFE, 8'hFF, 8'hFF);
    // wide value saturates
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd3001, 8'h01, 8'h2C, 8'h01);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd3002, 8'hFF, 8'hFF, 8'hFF);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd3003, 8'h01, 8'hC8, 8'h00);
    // ring wraps
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd6003, 8'h00, 8'h50, 8'hA5);
    send_meas(hrarg_pkg::CMD_CLEAR, 32'h5A5A_5A5A, 8'hFF, 8'hFF, 8'hFF);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd9003, 8'h00, 8'h5A, 8'h00);
    // one short of the period
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd12002, 8'h00, 8'hB4, 8'h00);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd12003, 8'h00, 8'hB4, 8'h00);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'hFFFF_FFFF, 8'h01, 8'hFF, 8'h00);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd0, 8'h00, 8'h01, 8'h00);
    // wrapped difference below period
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd2998, 8'h00, 8'h3C, 8'h00);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd2999, 8'h00, 8'h3C, 8'h00);
    send_meas(hrarg_pkg::CMD_CLEAR, 32'd0, 8'h00, 8'h00, 8'h00);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd20000, 8'h00, 8'h00, 8'h00);
    send_meas(hrarg_pkg::CMD_MEASURE, 32'd30001, 8'h01, 8'h00, 8'hFF);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          mode = 1'b0; period = '0; crit_iv = '0; norm_iv = '1; thr = '0;
        end
        1: begin
          mode = 1'b1; period = '1; crit_iv = '0; norm_iv = '0; thr = 8'hFF;
        end
        default: begin
          mode    = $urandom_range(0, 1);
          period  = pick_span(hrarg_pkg::EVAL_PERIOD_RST);
          crit_iv = pick_span(hrarg_pkg::CRIT_INTERVAL_RST);
          norm_iv = pick_span(hrarg_pkg::NORM_INTERVAL_RST);
          thr     = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 40)) : 8'($urandom());
        end
      endcase
      noise = $urandom();
      write_reg(hrarg_pkg::CFG_CRITICAL_MODE, {noise[31:1], mode});
      write_reg(hrarg_pkg::CFG_EVALUATE_PERIOD, period);
      write_reg(hrarg_pkg::CFG_CRITICAL_INTERVAL, crit_iv);
      write_reg(hrarg_pkg::CFG_NORMAL_INTERVAL, norm_iv);
      noise = $urandom();
      write_reg(hrarg_pkg::CFG_CHANGE_THRESHOLD, {noise[31:8], thr});
      write_reg(hrarg_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_UNUSED_LO, CFG_IDX_UNUSED_HI)),
                $urandom());
      cfg_if.valid <= 1'b0;
      step_max = (period < 20000) ? period * 2 + 50 : 20000;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % STRETCH_ITEMS == 0) begin
          tx_idling   = ($urandom_range(0, 3) != 0);
          rx_stalling = ($urandom_range(0, 3) != 0);
        end
        case ($urandom_range(0, 15))
          0: stamp = $urandom();
          1: stamp = sb.last_eval_ms + sb.eval_period - 1 + $urandom_range(0, 2);
          2: stamp = sb.last_send_ms + (sb.crit_mode ? sb.crit_interval : sb.norm_interval)
                     + $urandom_range(0, 1);
          3: stamp = cur_ms;
          default: stamp = cur_ms + $urandom_range(0, step_max);
        endcase
        cmd   = ($urandom_range(0, 23) == 0) ? hrarg_pkg::CMD_CLEAR : hrarg_pkg::CMD_MEASURE;
        flags = $urandom();
        hi    = ($urandom_range(0, 2) == 0) ? 8'($urandom()) : 8'h00;
        lo    = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(40, 200));
        send_meas(cmd, stamp, flags, lo, hi);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.expected_reports.size() != 0) begin
      sb.flag_failure($sformatf("%0d reports never arrived", sb.expected_reports.size()));
    end
    if (sb.failures == 0) begin
      $display("** heart_rate_average_report_gate_core: PASSED **");
    end else begin
      $display("** heart_rate_average_report_gate_core: FAILED **");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    report_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = rx_stalling ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        report_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      report_if.ready <= 1'b1;
      do @(posedge clk_i); while (report_if.valid !== 1'b1);
      sb.check_report(report_if.data);
    end
  end

  // cycles since the last transaction on any channel
  always @(posedge clk_i) begin
    if ((meas_if.valid && meas_if.ready) || (report_if.valid && report_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** heart_rate_average_report_gate_core: FAILED **");
      $finish;
    end
  end

endmodule
